FILE: design/ctq_pkg.sv
// Shared types, constants and codes for the CAN transmit frame queue.
package ctq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W      = 29;
    localparam int DATA_W    = 64;
    localparam int LEN_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int CLASS_W   = 2;
    localparam int LIMIT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_BYTES = 8;

    localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST = LIMIT_W'(3);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_POLL    = 2'd1,
        CMD_DONE    = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_TX_ERROR = 3'd3,
        ST_IDLE     = 3'd4
    } t_status;

    typedef enum logic [CLASS_W-1:0] {
        CLS_ABORTED = 2'd0,
        CLS_MATCH   = 2'd1,
        CLS_OTHER   = 2'd2
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_ID    = 2'd0,
        CFG_SECOND_ID   = 2'd1,
        CFG_TX_ENABLE   = 2'd2,
        CFG_STALL_LIMIT = 2'd3
    } t_cfg_idx;

    // Last frame handed to the transmitter.
    typedef enum logic [2:0] {
        LF_IDLE   = 3'b001,
        LF_FLIGHT = 3'b010,
        LF_SENT   = 3'b100
    } t_last_state;

    // Classified command as it travels from the front end to the back end.
    typedef struct packed {
        t_cmd              cmd;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;     // bytes at or beyond len already zeroed
        logic [LEN_W-1:0]  len;
        logic              accept;
        logic              match;    // id equals one of the configured ids
        logic              enq_ok;   // match and transmit enabled
        logic              len_bad;  // more than MAX_BYTES bytes
    } t_ctq_item;

endpackage

FILE: design/can_tx_frame_queue_core.sv
// Top level of the CAN transmit frame queue: config registers, front end, queue, back end.
// A taken command passes through the command queue, then the back end's result register.
// Throughput: one command per cycle, set by the back end executing one command per cycle.
// The receiver cannot stall; results are registered and shown for exactly one cycle.
// Reset (synchronous, active low) empties the ring and the command queue, sets the last
// frame to idle, clears stall count and abort, and restores the config reset values.
module can_tx_frame_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_command,
    input  logic [ctq_pkg::ID_W-1:0]          i_frame_id,
    input  logic [ctq_pkg::DATA_W-1:0]        i_frame_data,
    input  logic [ctq_pkg::LEN_W-1:0]         i_frame_len,
    input  logic                              i_send_accepted,
    // Result channel
    output logic                              o_strobe,
    output logic [ctq_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_send_valid,
    output logic [ctq_pkg::ID_W-1:0]          o_out_id,
    output logic [ctq_pkg::DATA_W-1:0]        o_out_data,
    output logic [ctq_pkg::LEN_W-1:0]         o_out_len,
    output logic [ctq_pkg::CLASS_W-1:0]       o_done_class,
    output logic                              o_flushed,
    // Config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ctq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctq_pkg::ID_W-1:0]          i_cfg_data
);

    logic [ctq_pkg::ID_W-1:0]    r_first_id;
    logic [ctq_pkg::ID_W-1:0]    r_second_id;
    logic                        r_tx_enable;
    logic [ctq_pkg::LIMIT_W-1:0] r_stall_limit;

    ctq_pkg::t_ctq_item          front_item;
    ctq_pkg::t_ctq_item          head_item;
    logic                        head_valid;
    logic                        fifo_full;
    logic                        cfg_write;

    // Config writes are registered; the port never pushes back.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id    <= '0;
            r_second_id   <= '0;
            r_tx_enable   <= 1'b0;
            r_stall_limit <= ctq_pkg::STALL_LIMIT_RST;
        end else if (cfg_write) begin
            case (ctq_pkg::t_cfg_idx'(i_cfg_index))
                ctq_pkg::CFG_FIRST_ID:    r_first_id    <= i_cfg_data;
                ctq_pkg::CFG_SECOND_ID:   r_second_id   <= i_cfg_data;
                ctq_pkg::CFG_TX_ENABLE:   r_tx_enable   <= i_cfg_data[0];
                ctq_pkg::CFG_STALL_LIMIT: r_stall_limit <= i_cfg_data[ctq_pkg::LIMIT_W-1:0];
                default:                  r_tx_enable   <= r_tx_enable;
            endcase
        end
    end

    // Classify the command as it arrives: id match, length check, byte trim.
    ctq_front u_front (
        .i_command       (i_command),
        .i_frame_id      (i_frame_id),
        .i_frame_data    (i_frame_data),
        .i_frame_len     (i_frame_len),
        .i_send_accepted (i_send_accepted),
        .i_first_id      (r_first_id),
        .i_second_id     (r_second_id),
        .i_tx_enable     (r_tx_enable),
        .o_item          (front_item)
    );

    // Hold classified commands until the back end takes them; busy only when full.
    assign busy = fifo_full;

    ctq_cmd_fifo u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (start && !busy),
        .i_push_item  (front_item),
        .i_pop        (head_valid),
        .o_head       (head_item),
        .o_head_valid (head_valid),
        .o_full       (fifo_full)
    );

    // Execute one command per cycle against the ring and transmit state.
    ctq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (head_valid),
        .i_item        (head_item),
        .i_stall_limit (r_stall_limit),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_send_valid  (o_send_valid),
        .o_out_id      (o_out_id),
        .o_out_data    (o_out_data),
        .o_out_len     (o_out_len),
        .o_done_class  (o_done_class),
        .o_flushed     (o_flushed)
    );

endmodule

FILE: design/ctq_front.sv
// Front end: classifies an incoming command and trims its data bytes.
module ctq_front (
    input  logic [1:0]                  i_command,
    input  logic [ctq_pkg::ID_W-1:0]    i_frame_id,
    input  logic [ctq_pkg::DATA_W-1:0]  i_frame_data,
    input  logic [ctq_pkg::LEN_W-1:0]   i_frame_len,
    input  logic                        i_send_accepted,
    input  logic [ctq_pkg::ID_W-1:0]    i_first_id,
    input  logic [ctq_pkg::ID_W-1:0]    i_second_id,
    input  logic                        i_tx_enable,
    output ctq_pkg::t_ctq_item          o_item
);

    logic                       match;
    logic [ctq_pkg::DATA_W-1:0] kept;

    assign match = (i_frame_id == i_first_id) || (i_frame_id == i_second_id);

    // Zero every byte at or beyond the length.
    always_comb begin
        for (int b = 0; b < ctq_pkg::MAX_BYTES; b++) begin
            kept[b*8 +: 8] = (ctq_pkg::LEN_W'(b) < i_frame_len) ? i_frame_data[b*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        o_item.cmd     = ctq_pkg::t_cmd'(i_command);
        o_item.id      = i_frame_id;
        o_item.data    = kept;
        o_item.len     = i_frame_len;
        o_item.accept  = i_send_accepted;
        o_item.match   = match;
        o_item.enq_ok  = match && i_tx_enable;
        o_item.len_bad = i_frame_len > ctq_pkg::LEN_W'(ctq_pkg::MAX_BYTES);
    end

endmodule

FILE: design/ctq_cmd_fifo.sv
// Short command queue between the front end and the back end.
module ctq_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ctq_pkg::t_ctq_item  i_push_item,
    input  logic                i_pop,
    output ctq_pkg::t_ctq_item  o_head,
    output logic                o_head_valid,
    output logic                o_full
);

    ctq_pkg::t_ctq_item                r_mem [ctq_pkg::CMDQ_DEPTH];
    logic [ctq_pkg::CMDQ_PTR_W-1:0]    r_wr_ptr;
    logic [ctq_pkg::CMDQ_PTR_W-1:0]    r_rd_ptr;
    logic [ctq_pkg::CMDQ_CNT_W-1:0]    r_count;
    logic [ctq_pkg::CMDQ_PTR_W-1:0]    n_wr_ptr;
    logic [ctq_pkg::CMDQ_PTR_W-1:0]    n_rd_ptr;
    logic [ctq_pkg::CMDQ_CNT_W-1:0]    n_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_full       = r_count == ctq_pkg::CMDQ_CNT_W'(ctq_pkg::CMDQ_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == ctq_pkg::CMDQ_PTR_W'(ctq_pkg::CMDQ_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == ctq_pkg::CMDQ_PTR_W'(ctq_pkg::CMDQ_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: design/ctq_back.sv
// Back end: frame ring, transmit state, stall timeout and result register.
module ctq_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_item_valid,
    input  ctq_pkg::t_ctq_item             i_item,
    input  logic [ctq_pkg::LIMIT_W-1:0]    i_stall_limit,
    output logic                           o_strobe,
    output logic [ctq_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_send_valid,
    output logic [ctq_pkg::ID_W-1:0]       o_out_id,
    output logic [ctq_pkg::DATA_W-1:0]     o_out_data,
    output logic [ctq_pkg::LEN_W-1:0]      o_out_len,
    output logic [ctq_pkg::CLASS_W-1:0]    o_done_class,
    output logic                           o_flushed
);

    // Frame ring, undefined until written.
    logic [ctq_pkg::ID_W-1:0]     r_slot_id   [ctq_pkg::QUEUE_DEPTH];
    logic [ctq_pkg::LEN_W-1:0]    r_slot_len  [ctq_pkg::QUEUE_DEPTH];
    logic [ctq_pkg::DATA_W-1:0]   r_slot_data [ctq_pkg::QUEUE_DEPTH];

    logic [ctq_pkg::PTR_W-1:0]    r_wr_ptr,  n_wr_ptr;
    logic [ctq_pkg::PTR_W-1:0]    r_rd_ptr,  n_rd_ptr;
    logic [ctq_pkg::CNT_W-1:0]    r_fill,    n_fill;
    ctq_pkg::t_last_state         r_last,    n_last;
    logic [ctq_pkg::ID_W-1:0]     r_last_id, n_last_id;
    logic [ctq_pkg::LEN_W-1:0]    r_last_len, n_last_len;
    logic [ctq_pkg::DATA_W-1:0]   r_last_data, n_last_data;
    logic [ctq_pkg::LIMIT_W-1:0]  r_stall,   n_stall;
    logic                         r_abort,   n_abort;

    logic                         r_strobe;
    logic [ctq_pkg::STATUS_W-1:0] r_status,  n_status;
    logic                         r_send,    n_send;
    logic [ctq_pkg::ID_W-1:0]     r_oid,     n_oid;
    logic [ctq_pkg::DATA_W-1:0]   r_odata,   n_odata;
    logic [ctq_pkg::LEN_W-1:0]    r_olen,    n_olen;
    logic [ctq_pkg::CLASS_W-1:0]  r_cls,     n_cls;
    logic                         r_flushed, n_flushed;

    logic                         slot_we;
    logic [ctq_pkg::LIMIT_W-1:0]  stall_inc;

    assign stall_inc = (r_stall == '1) ? r_stall : r_stall + 1'b1;

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_fill      = r_fill;
        n_last      = r_last;
        n_last_id   = r_last_id;
        n_last_len  = r_last_len;
        n_last_data = r_last_data;
        n_stall     = r_stall;
        n_abort     = r_abort;
        n_status    = ctq_pkg::ST_OK;
        n_send      = 1'b0;
        n_oid       = '0;
        n_odata     = '0;
        n_olen      = '0;
        n_cls       = ctq_pkg::CLS_ABORTED;
        n_flushed   = 1'b0;
        slot_we     = 1'b0;

        if (i_item_valid) begin
            case (i_item.cmd)
                ctq_pkg::CMD_ENQUEUE: begin
                    if (i_item.enq_ok) begin
                        if (r_fill == ctq_pkg::CNT_W'(ctq_pkg::QUEUE_DEPTH)) begin
                            n_status = ctq_pkg::ST_FULL;
                        end else if (i_item.len_bad) begin
                            n_status = ctq_pkg::ST_TOO_LONG;
                        end else begin
                            slot_we  = 1'b1;
                            n_wr_ptr = (r_wr_ptr == ctq_pkg::PTR_W'(ctq_pkg::QUEUE_DEPTH - 1))
                                       ? '0 : r_wr_ptr + 1'b1;
                            n_fill   = r_fill + 1'b1;
                        end
                    end
                end
                ctq_pkg::CMD_POLL: begin
                    if (r_last == ctq_pkg::LF_FLIGHT) begin
                        // Count the stalled poll; flush once the limit is reached.
                        n_stall = stall_inc;
                        if (stall_inc >= i_stall_limit) begin
                            n_wr_ptr  = '0;
                            n_rd_ptr  = '0;
                            n_fill    = '0;
                            n_last    = ctq_pkg::LF_IDLE;
                            n_stall   = '0;
                            n_abort   = 1'b1;
                            n_status  = ctq_pkg::ST_TX_ERROR;
                            n_flushed = 1'b1;
                        end
                    end else begin
                        n_stall = '0;
                        if (r_fill != '0) begin
                            if (i_item.accept) begin
                                n_last_id   = r_slot_id[r_rd_ptr];
                                n_last_len  = r_slot_len[r_rd_ptr];
                                n_last_data = r_slot_data[r_rd_ptr];
                                n_last      = ctq_pkg::LF_FLIGHT;
                                n_rd_ptr    = (r_rd_ptr == ctq_pkg::PTR_W'(ctq_pkg::QUEUE_DEPTH - 1))
                                              ? '0 : r_rd_ptr + 1'b1;
                                n_fill      = r_fill - 1'b1;
                                n_send      = 1'b1;
                                n_oid       = r_slot_id[r_rd_ptr];
                                n_odata     = r_slot_data[r_rd_ptr];
                                n_olen      = r_slot_len[r_rd_ptr];
                            end else begin
                                n_status = ctq_pkg::ST_TX_ERROR;
                            end
                        end
                    end
                end
                ctq_pkg::CMD_DONE: begin
                    n_last = ctq_pkg::LF_SENT;
                    if (r_abort) begin
                        n_abort = 1'b0;
                        n_cls   = ctq_pkg::CLS_ABORTED;
                    end else begin
                        n_cls = i_item.match ? ctq_pkg::CLS_MATCH : ctq_pkg::CLS_OTHER;
                    end
                end
                ctq_pkg::CMD_READ: begin
                    if (r_last == ctq_pkg::LF_IDLE) begin
                        n_status = ctq_pkg::ST_IDLE;
                    end else begin
                        n_oid   = r_last_id;
                        n_odata = r_last_data;
                        n_olen  = r_last_len;
                    end
                end
                default: begin
                    n_status = ctq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_id[r_wr_ptr]   <= i_item.id;
            r_slot_len[r_wr_ptr]  <= i_item.len;
            r_slot_data[r_wr_ptr] <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_send    <= n_send;
        r_oid     <= n_oid;
        r_odata   <= n_odata;
        r_olen    <= n_olen;
        r_cls     <= n_cls;
        r_flushed <= n_flushed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_last      <= ctq_pkg::LF_IDLE;
            r_last_id   <= '0;
            r_last_len  <= '0;
            r_last_data <= '0;
            r_stall     <= '0;
            r_abort     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_last      <= n_last;
            r_last_id   <= n_last_id;
            r_last_len  <= n_last_len;
            r_last_data <= n_last_data;
            r_stall     <= n_stall;
            r_abort     <= n_abort;
            r_strobe    <= i_item_valid;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_send_valid = r_send;
    assign o_out_id     = r_oid;
    assign o_out_data   = r_odata;
    assign o_out_len    = r_olen;
    assign o_done_class = r_cls;
    assign o_flushed    = r_flushed;

endmodule
